// File: src/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/crt_pkg.sv
// Shared types and constants of the incremental CRT combiner.
`timescale 1ns / 1ps
package crt_pkg;

   localparam int DEF_INPUT_BITS    = 32;
   localparam int DEF_COMBINED_BITS = 62;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOSOL = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE, OP_BMOD, OP_GCD, OP_RMOD, OP_DDIV, OP_MDIV, OP_PROD,
      OP_MQ, OP_MM, OP_EDIV, OP_EMUL, OP_TMUL, OP_RUPD
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_BMOD, S_GCD, S_RMOD, S_DDIV, S_MDIV, S_PROD,
      S_MQ, S_MM, S_ECHK, S_EDIV, S_EMUL, S_TMUL, S_RUPD, S_FINISH
   } state_type;

   typedef struct packed {
      logic   load;
      logic   go;
      op_type op;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic fail;
      logic md_one;
      logic r1_zero;
   } sts_type;

endpackage

// File: src/crt_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module crt_div #(
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [DW-1:0] quo,
   output logic [DW-1:0] rem
);
   localparam int CW = $clog2(DW);

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [DW:0]   trial, diffv;
   logic          fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      diffv = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? diffv[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule

// File: src/crt_mul.sv
// Shift-add multiplier, plain with overflow flag or modulo n, one bit per cycle.
`timescale 1ns / 1ps
module crt_mul #(
   parameter int DW = 64,
   parameter int C  = 62
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          mod_mode,
   input  logic [DW-1:0] a,
   input  logic [DW-1:0] b,
   input  logic [DW-1:0] n,
   output logic          done,
   output logic [DW-1:0] prod,
   output logic          ovf
);
   localparam int AW = DW + 1;
   localparam int CW = $clog2(DW);
   localparam logic [AW-1:0] LIMIT = AW'(1) << C;

   logic          busy_ff, busy_in, done_ff, done_in, ovf_ff, ovf_in;
   logic          mod_ff, mod_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] acc_ff, acc_in, dbl, d1, sum, d2, nx;
   logic [DW-1:0] a_ff, a_in, b_ff, b_in, n_ff, n_in;

   always_comb begin
      nx  = {1'b0, n_ff};
      dbl = {acc_ff[AW-2:0], 1'b0};
      d1  = (mod_ff && dbl >= nx) ? dbl - nx : dbl;
      sum = b_ff[DW-1] ? d1 + {1'b0, a_ff} : d1;
      d2  = (mod_ff && sum >= nx) ? sum - nx : sum;
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      n_in    = n_ff;
      if (start) begin
         busy_in = 1'b1;
         ovf_in  = 1'b0;
         mod_in  = mod_mode;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
         n_in    = n;
      end else if (busy_ff) begin
         b_in   = {b_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (!ovf_ff) begin
            if (!mod_ff && d2 > LIMIT) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = d2;
            end
         end
         if (cnt_ff == CW'(DW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ovf_ff <= ovf_in;
      mod_ff <= mod_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      n_ff   <= n_in;
   end

   assign done = done_ff;
   assign prod = acc_ff[DW-1:0];
   assign ovf  = ovf_ff;
endmodule

// File: src/crt_dp.sv
// Datapath: running system, operand registers, gcd, divider and multiplier.
`timescale 1ns / 1ps
module crt_dp import crt_pkg::*; #(
   parameter int INPUT_BITS    = DEF_INPUT_BITS,
   parameter int COMBINED_BITS = DEF_COMBINED_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_start_req,
   input  logic [INPUT_BITS-1:0]    req_residue_in,
   input  logic [INPUT_BITS-1:0]    req_modulus_in,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   output logic [COMBINED_BITS-1:0] rsp_combined_residue,
   output logic [COMBINED_BITS:0]   rsp_combined_modulus,
   output logic [1:0]               rsp_status
);
   localparam int C  = COMBINED_BITS;
   localparam int DW = ((INPUT_BITS > C) ? INPUT_BITS : C) + 2;
   localparam int KW = $clog2(DW + 1);

   logic [C-1:0]  res_ff, res_in, o_res_ff, o_res_in;
   logic [C:0]    mod_ff, mod_in, mnew_ff, mnew_in, o_mod_ff, o_mod_in;
   logic [1:0]    fail_ff, fail_in, o_st_ff, o_st_in;
   logic          done_ff, done_in;
   op_type        op_ff, op_in;
   logic [DW-1:0] b_ff, b_in, m_ff, m_in, d_ff, d_in, md_ff, md_in;
   logic [DW-1:0] diff_ff, diff_in, q_ff, q_in, x_ff, x_in, t_ff, t_in;
   logic [DW-1:0] r0_ff, r0_in, r1_ff, r1_in, s0_ff, s0_in, s1_ff, s1_in;
   logic [DW-1:0] qt_ff, qt_in, rt_ff, rt_in, st, rmv;
   logic [DW-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [KW-1:0] gk_ff, gk_in;
   logic          gbusy_ff, gbusy_in, gshift_ff, gshift_in;

   logic          div_start, div_done;
   logic [DW-1:0] div_num, div_den, div_quo, div_rem;
   logic          mul_start, mul_mode, mul_done, mul_ovf;
   logic [DW-1:0] mul_a, mul_b, mul_n, mul_prod;

   crt_div #(.DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_quo), .rem(div_rem)
   );

   crt_mul #(.DW(DW), .C(C)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .mod_mode(mul_mode),
      .a(mul_a), .b(mul_b), .n(mul_n), .done(mul_done), .prod(mul_prod), .ovf(mul_ovf)
   );

   // Operand selection for the shared units.
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mul_start = 1'b0;
      mul_mode  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mul_n     = '0;
      if (cmd.go) begin
         unique case (cmd.op)
            OP_BMOD: begin div_start = 1'b1; div_num = b_ff;       div_den = m_ff;  end
            OP_RMOD: begin div_start = 1'b1; div_num = DW'(res_ff); div_den = m_ff; end
            OP_DDIV: begin div_start = 1'b1; div_num = diff_ff;    div_den = d_ff;  end
            OP_MDIV: begin div_start = 1'b1; div_num = m_ff;       div_den = d_ff;  end
            OP_MQ:   begin div_start = 1'b1; div_num = DW'(mod_ff); div_den = d_ff; end
            OP_MM:   begin div_start = 1'b1; div_num = x_ff;       div_den = md_ff; end
            OP_EDIV: begin div_start = 1'b1; div_num = r0_ff;      div_den = r1_ff; end
            OP_PROD: begin
               mul_start = 1'b1;
               mul_a     = DW'(mod_ff);
               mul_b     = md_ff;
            end
            OP_EMUL: begin
               mul_start = 1'b1;
               mul_mode  = 1'b1;
               mul_a     = (qt_ff == md_ff) ? '0 : qt_ff;
               mul_b     = s1_ff;
               mul_n     = md_ff;
            end
            OP_TMUL: begin
               mul_start = 1'b1;
               mul_mode  = 1'b1;
               mul_a     = q_ff;
               mul_b     = s0_ff;
               mul_n     = md_ff;
            end
            OP_RUPD: begin
               mul_start = 1'b1;
               mul_a     = DW'(mod_ff);
               mul_b     = t_ff;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      res_in = res_ff;   mod_in = mod_ff;   fail_in = fail_ff; mnew_in = mnew_ff;
      o_res_in = o_res_ff; o_mod_in = o_mod_ff; o_st_in = o_st_ff;
      done_in = 1'b0;    op_in = op_ff;
      b_in = b_ff;   m_in = m_ff;   d_in = d_ff;   md_in = md_ff;
      diff_in = diff_ff; q_in = q_ff; x_in = x_ff; t_in = t_ff;
      r0_in = r0_ff; r1_in = r1_ff; s0_in = s0_ff; s1_in = s1_ff;
      qt_in = qt_ff; rt_in = rt_ff;
      gx_in = gx_ff; gy_in = gy_ff; gk_in = gk_ff;
      gbusy_in = gbusy_ff; gshift_in = gshift_ff;
      rmv = div_rem;
      st  = (s0_ff >= mul_prod) ? s0_ff - mul_prod : s0_ff + (md_ff - mul_prod);

      // Take a request: restart the system if asked, latch the congruence.
      if (cmd.load) begin
         if (req_start_req) begin
            res_in  = '0;
            mod_in  = (C+1)'(1);
            fail_in = ST_OK;
         end
         b_in = DW'(req_residue_in);
         m_in = (req_modulus_in == '0) ? DW'(1) : DW'(req_modulus_in);
      end

      if (cmd.go) begin
         op_in = cmd.op;
         if (cmd.op == OP_GCD) begin
            gx_in     = DW'(mod_ff);
            gy_in     = m_ff;
            gk_in     = '0;
            gbusy_in  = 1'b1;
            gshift_in = 1'b0;
         end
      end

      // Binary gcd: strip common twos, subtract to equality, shift back.
      if (gbusy_ff) begin
         if (gshift_ff) begin
            if (gk_ff == '0) begin
               d_in     = gx_ff;
               gbusy_in = 1'b0;
               done_in  = 1'b1;
            end else begin
               gx_in = {gx_ff[DW-2:0], 1'b0};
               gk_in = gk_ff - KW'(1);
            end
         end else if (gx_ff == gy_ff) begin
            gshift_in = 1'b1;
         end else if (!gx_ff[0] && !gy_ff[0]) begin
            gx_in = gx_ff >> 1;
            gy_in = gy_ff >> 1;
            gk_in = gk_ff + KW'(1);
         end else if (!gx_ff[0]) begin
            gx_in = gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_in = gy_ff >> 1;
         end else if (gx_ff > gy_ff) begin
            gx_in = gx_ff - gy_ff;
         end else begin
            gy_in = gy_ff - gx_ff;
         end
      end

      if (div_done) begin
         done_in = 1'b1;
         case (op_ff)
            OP_BMOD: b_in = div_rem;
            OP_RMOD: diff_in = (b_ff >= rmv) ? b_ff - rmv : b_ff + (m_ff - rmv);
            OP_DDIV: begin
               q_in = div_quo;
               if (div_rem != '0) begin
                  fail_in = ST_NOSOL;
                  res_in  = '0;
                  mod_in  = '0;
               end
            end
            OP_MDIV: md_in = div_quo;
            OP_MQ:   x_in = div_quo;
            OP_MM: begin
               r0_in = md_ff;
               r1_in = div_rem;
               s0_in = '0;
               s1_in = DW'(1);
            end
            OP_EDIV: begin
               qt_in = div_quo;
               rt_in = div_rem;
            end
            default: ;
         endcase
      end

      if (mul_done) begin
         done_in = 1'b1;
         case (op_ff)
            OP_PROD: begin
               if (mul_ovf) begin
                  fail_in = ST_OVF;
                  res_in  = '0;
                  mod_in  = '0;
               end else begin
                  mnew_in = mul_prod[C:0];
               end
            end
            OP_EMUL: begin
               r0_in = r1_ff;
               r1_in = rt_ff;
               s0_in = s1_ff;
               s1_in = st;
            end
            OP_TMUL: t_in = mul_prod;
            OP_RUPD: begin
               res_in = res_ff + mul_prod[C-1:0];
               mod_in = mnew_ff;
            end
            default: ;
         endcase
      end

      if (cmd.out_load) begin
         o_res_in = res_ff;
         o_mod_in = mod_ff;
         o_st_in  = fail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff   <= '0;
         mod_ff   <= (C+1)'(1);
         fail_ff  <= ST_OK;
         done_ff  <= 1'b0;
         op_ff    <= OP_NONE;
         gbusy_ff <= 1'b0;
      end else begin
         res_ff   <= res_in;
         mod_ff   <= mod_in;
         fail_ff  <= fail_in;
         done_ff  <= done_in;
         op_ff    <= op_in;
         gbusy_ff <= gbusy_in;
      end
      gshift_ff <= gshift_in;
      gx_ff <= gx_in;  gy_ff <= gy_in;  gk_ff <= gk_in;
      mnew_ff <= mnew_in;
      o_res_ff <= o_res_in; o_mod_ff <= o_mod_in; o_st_ff <= o_st_in;
      b_ff <= b_in;   m_ff <= m_in;   d_ff <= d_in;   md_ff <= md_in;
      diff_ff <= diff_in; q_ff <= q_in; x_ff <= x_in; t_ff <= t_in;
      r0_ff <= r0_in; r1_ff <= r1_in; s0_ff <= s0_in; s1_ff <= s1_in;
      qt_ff <= qt_in; rt_ff <= rt_in;
   end

   always_comb begin
      sts.done    = done_ff;
      sts.fail    = (fail_ff != ST_OK);
      sts.md_one  = (md_ff == DW'(1));
      sts.r1_zero = (r1_ff == '0);
   end

   assign rsp_combined_residue = o_res_ff;
   assign rsp_combined_modulus = o_mod_ff;
   assign rsp_status           = o_st_ff;
endmodule

// File: src/crt_ctrl.sv
// Controller: sequences the datapath operations and runs both handshakes.
`timescale 1ns / 1ps
module crt_ctrl import crt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   logic      issued_ff, issued_in, rsp_valid_ff, rsp_valid_in;
   op_type    op;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_CHECK;
         S_CHECK:  state_in = sts.fail ? S_FINISH : S_BMOD;
         S_BMOD:   if (sts.done) state_in = S_GCD;
         S_GCD:    if (sts.done) state_in = S_RMOD;
         S_RMOD:   if (sts.done) state_in = S_DDIV;
         S_DDIV:   if (sts.done) state_in = sts.fail ? S_FINISH : S_MDIV;
         S_MDIV:   if (sts.done) state_in = S_PROD;
         S_PROD: begin
            if (sts.done) state_in = (sts.fail || sts.md_one) ? S_FINISH : S_MQ;
         end
         S_MQ:     if (sts.done) state_in = S_MM;
         S_MM:     if (sts.done) state_in = S_ECHK;
         S_ECHK:   state_in = sts.r1_zero ? S_TMUL : S_EDIV;
         S_EDIV:   if (sts.done) state_in = S_EMUL;
         S_EMUL:   if (sts.done) state_in = S_ECHK;
         S_TMUL:   if (sts.done) state_in = S_RUPD;
         S_RUPD:   if (sts.done) state_in = S_FINISH;
         S_FINISH: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_BMOD:  op = OP_BMOD;
         S_GCD:   op = OP_GCD;
         S_RMOD:  op = OP_RMOD;
         S_DDIV:  op = OP_DDIV;
         S_MDIV:  op = OP_MDIV;
         S_PROD:  op = OP_PROD;
         S_MQ:    op = OP_MQ;
         S_MM:    op = OP_MM;
         S_EDIV:  op = OP_EDIV;
         S_EMUL:  op = OP_EMUL;
         S_TMUL:  op = OP_TMUL;
         S_RUPD:  op = OP_RUPD;
         default: op = OP_NONE;
      endcase
      cmd.op       = op;
      cmd.go       = (op != OP_NONE) && !issued_ff;
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.out_load = (state_ff == S_FINISH) && out_free;
      req_stall    = (state_ff != S_IDLE);
      issued_in    = (op != OP_NONE) && !sts.done;
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// File: src/crt_incremental_combine.sv
// Top level of the incremental CRT combiner: controller, datapath and checks.
// Usage:
//   Request channel (req_valid / req_stall): one congruence x = residue mod modulus,
//   plus a start flag that restarts the running system at residue 0, modulus 1.
//   A modulus of 0 counts as 1. Each request yields exactly one response.
//   Response channel (rsp_valid / rsp_stall): running residue, running modulus
//   (the lcm so far) and status: ok, no solution or modulus overflow. Failures
//   are sticky and report zero residue and modulus until the next start.
// Sequencing:
//   One request at a time; req_stall stays high from acceptance until the
//   response is loaded. Division and multiplication passes run on the shared
//   serial divider and multiplier, both DW = max(INPUT_BITS, COMBINED_BITS) + 2
//   bits wide; the gcd runs as its own binary loop. The modular inverse repeats
//   rounds of one division, one multiplication and one check state; a sticky
//   failure or an lcm that does not grow skips the remaining steps.
// Reset: synchronous; clears the running system to residue 0, modulus 1, ok.
// Stall: a pending response holds while rsp_stall is high; the next request
//   is still taken and processed, and its response waits for the register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crt_incremental_combine import crt_pkg::*; #(
   parameter int INPUT_BITS    = DEF_INPUT_BITS,
   parameter int COMBINED_BITS = DEF_COMBINED_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_start_req,
   input  logic [INPUT_BITS-1:0]    req_residue_in,
   input  logic [INPUT_BITS-1:0]    req_modulus_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [COMBINED_BITS-1:0] rsp_combined_residue,
   output logic [COMBINED_BITS:0]   rsp_combined_modulus,
   output logic [1:0]               rsp_status
);
   cmd_type cmd;
   sts_type sts;

   // Sequence the fold: reduce, gcd, solvability, lcm, inverse, update.
   crt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   // Hold the running system and do the arithmetic.
   crt_dp #(.INPUT_BITS(INPUT_BITS), .COMBINED_BITS(COMBINED_BITS)) u_dp (
      .clock(clock), .reset(reset), .req_start_req(req_start_req),
      .req_residue_in(req_residue_in), .req_modulus_in(req_modulus_in),
      .cmd(cmd), .sts(sts), .rsp_combined_residue(rsp_combined_residue),
      .rsp_combined_modulus(rsp_combined_modulus), .rsp_status(rsp_status)
   );

   `CRT_ASSERT_NOW(a_fail_zero, clock, reset,
      rsp_valid && rsp_status != ST_OK,
      rsp_combined_residue == '0 && rsp_combined_modulus == '0,
      "failed response carries a nonzero pair")
   `CRT_ASSERT_NOW(a_res_below, clock, reset,
      rsp_valid && rsp_status == ST_OK,
      {1'b0, rsp_combined_residue} < rsp_combined_modulus,
      "residue not below modulus")
   `CRT_ASSERT_NEXT(a_busy, clock, reset,
      req_valid && !req_stall, req_stall,
      "block not busy after taking a request")
endmodule
